// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the bracket tape machine.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define BT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked on every rising edge outside reset.
`define BT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== src/bt_pkg.sv =====
// Package of the bracket tape machine: sizes, opcodes, command and status codes, types and symbol_op.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bt_pkg;
  localparam int TAPE_CELLS = 32768;
  localparam int PROGRAM_WORDS = 4096;
  localparam int NEST_DEPTH = 64;
  localparam int TAPE_AW = $clog2(TAPE_CELLS);
  localparam int PROG_AW = $clog2(PROGRAM_WORDS);
  localparam int STACK_AW = $clog2(NEST_DEPTH);
  localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
  localparam int COUNT_W = 13;
  localparam int WORD_W = 15;

  localparam logic [3:0] OP_INC = 4'd0;
  localparam logic [3:0] OP_DEC = 4'd1;
  localparam logic [3:0] OP_LEFT = 4'd2;
  localparam logic [3:0] OP_RIGHT = 4'd3;
  localparam logic [3:0] OP_OPEN = 4'd4;
  localparam logic [3:0] OP_CLOSE = 4'd5;
  localparam logic [3:0] OP_PUT = 4'd6;
  localparam logic [3:0] OP_GET = 4'd7;
  localparam logic [3:0] OP_HALT = 4'd8;
  localparam logic [3:0] OP_NONE = 4'd15;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_RUN = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_OUTPUT = 3'd1;
  localparam logic [2:0] ST_NEED_INPUT = 3'd2;
  localparam logic [2:0] ST_HALTED = 3'd3;
  localparam logic [2:0] ST_STEP_LIMIT = 3'd4;
  localparam logic [2:0] ST_BRACKET = 3'd5;
  localparam logic [2:0] ST_FULL = 3'd6;
  localparam logic [2:0] ST_NOT_LOADED = 3'd7;

  localparam logic [31:0] STEP_LIMIT_RESET = 32'd1000000;

  typedef enum logic [1:0] {
    MODE_LOADING, MODE_READY, MODE_HALTED_M, MODE_BROKEN
  } mode_t;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_CLOSE, S_RUN_TOP, S_RUN_OP, S_RUN_JMP, S_RUN_CELL
  } state_t;

  function automatic logic [3:0] symbol_op(input logic [7:0] ch);
    case (ch)
      8'h2B: symbol_op = OP_INC;
      8'h2D: symbol_op = OP_DEC;
      8'h3C: symbol_op = OP_LEFT;
      8'h3E: symbol_op = OP_RIGHT;
      8'h5B: symbol_op = OP_OPEN;
      8'h5D: symbol_op = OP_CLOSE;
      8'h2E: symbol_op = OP_PUT;
      8'h2C: symbol_op = OP_GET;
      default: symbol_op = OP_NONE;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== src/bt_ram.sv =====
// Generic RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module bt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/bracket_tape_machine_unit.sv =====
// Top level of the bracket tape machine: command decode, loader and interpreter.
// Depends on bt_pkg, bt_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// A command is taken when start is high and busy is low; its one result shows on
// the out_ ports for a single cycle with out_strobe, and the receiver cannot stall.
// Load and finish commands answer in the cycle after acceptance, but a closing
// bracket first reads the bracket stack and then writes both target words, in
// S_CLOSE and S_RUN_CELL. A run executes each instruction as a program memory fetch
// in S_RUN_TOP, then execution in S_RUN_OP, with S_RUN_JMP or S_RUN_CELL added for a
// taken bracket jump or a pointer move, which refetch from the program or tape
// memory, so the length of a run is set by the program and the step limit. After
// reset or a clear command, a sweep zeroes all 32768 tape cells while busy stays high.
module bracket_tape_machine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_source_char,
  input  wire logic [7:0]  in_in_byte,
  input  wire logic        in_in_valid,
  input  wire logic        in_in_eof,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [7:0]       out_out_byte,
  output logic [12:0]      out_program_length,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  bt_pkg::state_t state_r, state_nxt;
  bt_pkg::mode_t mode_r, mode_nxt;
  logic [31:0] limit_r;
  logic [31:0] steps_r, steps_nxt;
  logic [bt_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [bt_pkg::COUNT_W-1:0] planted_r, planted_nxt;
  logic [bt_pkg::COUNT_W-1:0] ip_r, ip_nxt;
  logic [bt_pkg::TAPE_AW-1:0] cp_r, cp_nxt;
  logic [bt_pkg::TAPE_AW-1:0] sweep_r, sweep_nxt;
  logic [2:0] fault_r, fault_nxt;
  logic [7:0] cell_r, cell_nxt;
  logic consumed_r, consumed_nxt;
  logic clr_reply_r, clr_reply_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic valid_r, valid_nxt, eof_r, eof_nxt;
  logic strobe_r, strobe_nxt;
  logic [2:0] status_r, status_nxt;
  logic [7:0] obyte_r, obyte_nxt;

  logic prog_we, tape_we, stack_we;
  logic [bt_pkg::PROG_AW-1:0] prog_waddr, prog_raddr;
  logic [bt_pkg::WORD_W-1:0] prog_wdata, prog_rdata;
  logic [bt_pkg::TAPE_AW-1:0] tape_waddr, tape_raddr;
  logic [7:0] tape_wdata, tape_rdata;
  logic [bt_pkg::STACK_AW-1:0] stack_waddr, stack_raddr;
  logic [bt_pkg::PROG_AW-1:0] stack_wdata, stack_rdata;

  logic [3:0] lop, op;
  logic [bt_pkg::COUNT_W:0] need_end;
  logic [bt_pkg::COUNT_W-1:0] ip_inc, ip_inc2;

  bt_ram #(.WIDTH(bt_pkg::WORD_W), .DEPTH(bt_pkg::PROGRAM_WORDS)) u_prog (
    .clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
    .raddr(prog_raddr), .rdata(prog_rdata)
  );
  bt_ram #(.WIDTH(8), .DEPTH(bt_pkg::TAPE_CELLS)) u_tape (
    .clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
    .raddr(tape_raddr), .rdata(tape_rdata)
  );
  bt_ram #(.WIDTH(bt_pkg::PROG_AW), .DEPTH(bt_pkg::NEST_DEPTH)) u_stack (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
    .raddr(stack_raddr), .rdata(stack_rdata)
  );

  assign busy = (state_r != bt_pkg::S_IDLE);
  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_out_byte = obyte_r;
  assign out_program_length = planted_r;
  assign ip_inc = ip_r + 1'b1;
  assign ip_inc2 = ip_r + 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bt_pkg::S_SWEEP;
      mode_r <= bt_pkg::MODE_LOADING;
      limit_r <= bt_pkg::STEP_LIMIT_RESET;
      steps_r <= '0;
      depth_r <= '0;
      planted_r <= '0;
      ip_r <= '0;
      cp_r <= '0;
      sweep_r <= '0;
      fault_r <= '0;
      cell_r <= '0;
      consumed_r <= 1'b0;
      clr_reply_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      steps_r <= steps_nxt;
      depth_r <= depth_nxt;
      planted_r <= planted_nxt;
      ip_r <= ip_nxt;
      cp_r <= cp_nxt;
      sweep_r <= sweep_nxt;
      fault_r <= fault_nxt;
      cell_r <= cell_nxt;
      consumed_r <= consumed_nxt;
      clr_reply_r <= clr_reply_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    valid_r <= valid_nxt;
    eof_r <= eof_nxt;
    status_r <= status_nxt;
    obyte_r <= obyte_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    steps_nxt = steps_r;
    depth_nxt = depth_r;
    planted_nxt = planted_r;
    ip_nxt = ip_r;
    cp_nxt = cp_r;
    sweep_nxt = sweep_r;
    fault_nxt = fault_r;
    cell_nxt = cell_r;
    consumed_nxt = consumed_r;
    clr_reply_nxt = clr_reply_r;
    byte_nxt = byte_r;
    valid_nxt = valid_r;
    eof_nxt = eof_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    obyte_nxt = obyte_r;
    prog_we = 1'b0;
    prog_waddr = planted_r[bt_pkg::PROG_AW-1:0];
    prog_wdata = '0;
    prog_raddr = ip_r[bt_pkg::PROG_AW-1:0];
    tape_we = 1'b0;
    tape_waddr = cp_r;
    tape_wdata = cell_r;
    tape_raddr = cp_r;
    stack_we = 1'b0;
    stack_waddr = depth_r[bt_pkg::STACK_AW-1:0];
    stack_wdata = planted_r[bt_pkg::PROG_AW-1:0] + 1'b1;
    stack_raddr = depth_r[bt_pkg::STACK_AW-1:0] - 1'b1;
    lop = bt_pkg::symbol_op(in_source_char);
    op = prog_rdata[3:0];
    need_end = {1'b0, planted_r} + 2'd1
             + ((lop == bt_pkg::OP_OPEN || lop == bt_pkg::OP_CLOSE) ? 2'd2 : 2'd1);

    case (state_r)
      bt_pkg::S_SWEEP: begin
        tape_we = 1'b1;
        tape_waddr = sweep_r;
        tape_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == bt_pkg::TAPE_AW'(bt_pkg::TAPE_CELLS - 1)) begin
          state_nxt = bt_pkg::S_IDLE;
          if (clr_reply_r) begin
            strobe_nxt = 1'b1;
            status_nxt = bt_pkg::ST_OK;
            obyte_nxt = '0;
          end
          clr_reply_nxt = 1'b0;
        end
      end
      bt_pkg::S_IDLE: begin
        if (start) begin
          status_nxt = bt_pkg::ST_OK;
          obyte_nxt = '0;
          strobe_nxt = 1'b1;
          byte_nxt = in_in_byte;
          valid_nxt = in_in_valid;
          eof_nxt = in_in_eof;
          case (in_command)
            bt_pkg::CMD_LOAD: begin
              if (mode_r == bt_pkg::MODE_LOADING && lop != bt_pkg::OP_NONE) begin
                if (lop == bt_pkg::OP_CLOSE && depth_r == '0) begin
                  status_nxt = bt_pkg::ST_BRACKET;
                  if (fault_r == '0) fault_nxt = bt_pkg::ST_BRACKET;
                end else if (lop == bt_pkg::OP_OPEN &&
                             depth_r >= bt_pkg::DEPTH_W'(bt_pkg::NEST_DEPTH)) begin
                  status_nxt = bt_pkg::ST_BRACKET;
                  if (fault_r == '0) fault_nxt = bt_pkg::ST_BRACKET;
                end else if (need_end > (bt_pkg::COUNT_W+1)'(bt_pkg::PROGRAM_WORDS)) begin
                  status_nxt = bt_pkg::ST_FULL;
                  if (fault_r == '0) fault_nxt = bt_pkg::ST_FULL;
                end else begin
                  prog_we = 1'b1;
                  prog_wdata = bt_pkg::WORD_W'(lop);
                  if (lop == bt_pkg::OP_OPEN) begin
                    stack_we = 1'b1;
                    depth_nxt = depth_r + 1'b1;
                    planted_nxt = planted_r + 2'd2;
                  end else if (lop == bt_pkg::OP_CLOSE) begin
                    strobe_nxt = 1'b0;
                    state_nxt = bt_pkg::S_CLOSE;
                    depth_nxt = depth_r - 1'b1;
                  end else begin
                    planted_nxt = planted_r + 1'b1;
                  end
                end
              end
            end
            bt_pkg::CMD_FINISH: begin
              if (mode_r == bt_pkg::MODE_LOADING) begin
                if (fault_r != '0) begin
                  status_nxt = fault_r;
                  mode_nxt = bt_pkg::MODE_BROKEN;
                end else if (depth_r != '0) begin
                  status_nxt = bt_pkg::ST_BRACKET;
                  mode_nxt = bt_pkg::MODE_BROKEN;
                end else begin
                  prog_we = 1'b1;
                  prog_wdata = bt_pkg::WORD_W'(bt_pkg::OP_HALT);
                  planted_nxt = planted_r + 1'b1;
                  ip_nxt = '0;
                  mode_nxt = bt_pkg::MODE_READY;
                end
              end
            end
            bt_pkg::CMD_RUN: begin
              if (mode_r == bt_pkg::MODE_READY) begin
                strobe_nxt = 1'b0;
                steps_nxt = '0;
                consumed_nxt = 1'b0;
                state_nxt = bt_pkg::S_RUN_TOP;
              end else if (mode_r == bt_pkg::MODE_HALTED_M) begin
                status_nxt = bt_pkg::ST_HALTED;
              end else begin
                status_nxt = bt_pkg::ST_NOT_LOADED;
              end
            end
            default: begin
              strobe_nxt = 1'b0;
              clr_reply_nxt = 1'b1;
              state_nxt = bt_pkg::S_SWEEP;
              sweep_nxt = '0;
              mode_nxt = bt_pkg::MODE_LOADING;
              depth_nxt = '0;
              planted_nxt = '0;
              ip_nxt = '0;
              cp_nxt = '0;
              fault_nxt = '0;
              cell_nxt = '0;
            end
          endcase
        end
      end
      bt_pkg::S_CLOSE: begin
        prog_we = 1'b1;
        prog_waddr = stack_rdata;
        prog_wdata = bt_pkg::WORD_W'(planted_r + 2'd2);
        planted_nxt = planted_r + 2'd2;
        ip_nxt = {1'b0, stack_rdata};
        state_nxt = bt_pkg::S_RUN_CELL;
        clr_reply_nxt = 1'b1;
      end
      bt_pkg::S_RUN_TOP: begin
        if (steps_r >= limit_r) begin
          strobe_nxt = 1'b1;
          status_nxt = bt_pkg::ST_STEP_LIMIT;
          state_nxt = bt_pkg::S_IDLE;
        end else if (ip_r >= planted_r) begin
          strobe_nxt = 1'b1;
          status_nxt = bt_pkg::ST_HALTED;
          mode_nxt = bt_pkg::MODE_HALTED_M;
          state_nxt = bt_pkg::S_IDLE;
        end else begin
          state_nxt = bt_pkg::S_RUN_OP;
        end
      end
      bt_pkg::S_RUN_OP: begin
        prog_raddr = ip_inc[bt_pkg::PROG_AW-1:0];
        state_nxt = bt_pkg::S_RUN_TOP;
        steps_nxt = steps_r + 1'b1;
        ip_nxt = ip_inc;
        if ((op == bt_pkg::OP_OPEN || op == bt_pkg::OP_CLOSE) && ip_inc >= planted_r) begin
          steps_nxt = steps_r;
          ip_nxt = ip_r;
          strobe_nxt = 1'b1;
          status_nxt = bt_pkg::ST_HALTED;
          mode_nxt = bt_pkg::MODE_HALTED_M;
          state_nxt = bt_pkg::S_IDLE;
        end else begin
          case (op)
            bt_pkg::OP_INC: begin
              cell_nxt = cell_r + 1'b1;
              tape_we = 1'b1;
              tape_wdata = cell_nxt;
            end
            bt_pkg::OP_DEC: begin
              cell_nxt = cell_r - 1'b1;
              tape_we = 1'b1;
              tape_wdata = cell_nxt;
            end
            bt_pkg::OP_LEFT: begin
              cp_nxt = cp_r - 1'b1;
              tape_raddr = cp_nxt;
              state_nxt = bt_pkg::S_RUN_CELL;
            end
            bt_pkg::OP_RIGHT: begin
              cp_nxt = cp_r + 1'b1;
              tape_raddr = cp_nxt;
              state_nxt = bt_pkg::S_RUN_CELL;
            end
            bt_pkg::OP_OPEN: begin
              if (cell_r == '0) state_nxt = bt_pkg::S_RUN_JMP;
              else ip_nxt = ip_inc2;
            end
            bt_pkg::OP_CLOSE: begin
              if (cell_r != '0) state_nxt = bt_pkg::S_RUN_JMP;
              else ip_nxt = ip_inc2;
            end
            bt_pkg::OP_PUT: begin
              steps_nxt = steps_r;
              strobe_nxt = 1'b1;
              status_nxt = bt_pkg::ST_OUTPUT;
              obyte_nxt = cell_r;
              state_nxt = bt_pkg::S_IDLE;
            end
            bt_pkg::OP_GET: begin
              if (valid_r && !consumed_r) begin
                cell_nxt = byte_r;
                tape_we = 1'b1;
                tape_wdata = byte_r;
                consumed_nxt = 1'b1;
              end else if (!eof_r) begin
                steps_nxt = steps_r;
                ip_nxt = ip_r;
                strobe_nxt = 1'b1;
                status_nxt = bt_pkg::ST_NEED_INPUT;
                state_nxt = bt_pkg::S_IDLE;
              end
            end
            default: begin
              steps_nxt = steps_r;
              ip_nxt = ip_r;
              strobe_nxt = 1'b1;
              status_nxt = bt_pkg::ST_HALTED;
              mode_nxt = bt_pkg::MODE_HALTED_M;
              state_nxt = bt_pkg::S_IDLE;
            end
          endcase
        end
      end
      bt_pkg::S_RUN_JMP: begin
        ip_nxt = prog_rdata[bt_pkg::COUNT_W-1:0];
        state_nxt = bt_pkg::S_RUN_TOP;
      end
      bt_pkg::S_RUN_CELL: begin
        if (clr_reply_r) begin
          // Second write of a closing bracket: its own target word.
          prog_we = 1'b1;
          prog_waddr = planted_r[bt_pkg::PROG_AW-1:0] - 1'b1;
          prog_wdata = bt_pkg::WORD_W'(ip_r + 1'b1);
          ip_nxt = '0;
          clr_reply_nxt = 1'b0;
          strobe_nxt = 1'b1;
          status_nxt = bt_pkg::ST_OK;
          obyte_nxt = '0;
          state_nxt = bt_pkg::S_IDLE;
        end else begin
          cell_nxt = tape_rdata;
          state_nxt = bt_pkg::S_RUN_TOP;
        end
      end
      default: begin
        state_nxt = bt_pkg::S_IDLE;
      end
    endcase
  end

  `BT_ASSERT(a_strobe_after_work, out_strobe |-> $past(start || busy), "result without work")
  `BT_ASSERT(a_accept_progress, (start && !busy) |=> (busy || out_strobe), "command lost")
  `BT_ASSERT_ALWAYS(a_depth_bound, depth_r <= bt_pkg::DEPTH_W'(bt_pkg::NEST_DEPTH), "overflow")
endmodule
`default_nettype wire

// ===== dv/bracket_tape_machine_unit_tb.sv =====
// Testbench of bracket_tape_machine_unit: directed and random command streams
// checked against a scoreboard that predicts every result. Depends on bt_pkg and bracket_tape_machine_unit.
`timescale 1ns / 1ps
module bracket_tape_machine_unit_tb;
  import bt_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  byte_out;
    logic [12:0] length;
  } tape_result_t;

  class tape_scoreboard;
    byte unsigned tape[TAPE_CELLS];
    int unsigned prog[PROGRAM_WORDS];
    int unsigned nest[NEST_DEPTH];
    int unsigned depth, planted, ip, cp;
    logic [31:0] limit;
    mode_t mode;
    logic [2:0] fault;
    tape_result_t pending[$];
    int errors;

    function new();
      limit = STEP_LIMIT_RESET;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (tape[i]) tape[i] = 0;
      depth = 0;
      planted = 0;
      ip = 0;
      cp = 0;
      mode = MODE_LOADING;
      fault = ST_OK;
    endfunction

    function int unsigned decode(logic [7:0] ch);
      case (ch)
        "+": return OP_INC;
        "-": return OP_DEC;
        "<": return OP_LEFT;
        ">": return OP_RIGHT;
        "[": return OP_OPEN;
        "]": return OP_CLOSE;
        ".": return OP_PUT;
        ",": return OP_GET;
        default: return OP_NONE;
      endcase
    endfunction

    function logic [2:0] flag(logic [2:0] code);
      if (fault == ST_OK) fault = code;
      return code;
    endfunction

    function logic [2:0] plant(logic [7:0] ch);
      int unsigned op, need, p, dst;
      op = decode(ch);
      need = (op == OP_OPEN || op == OP_CLOSE) ? 2 : 1;
      p = planted;
      if (op == OP_NONE) return ST_OK;
      if (op == OP_CLOSE && depth == 0) return flag(ST_BRACKET);
      if (op == OP_OPEN && depth >= NEST_DEPTH) return flag(ST_BRACKET);
      if (p + need + 1 > PROGRAM_WORDS) return flag(ST_FULL);
      prog[p] = op;
      if (op == OP_OPEN) begin
        prog[p + 1] = 0;
        nest[depth] = p + 1;
        depth++;
      end else if (op == OP_CLOSE) begin
        depth--;
        dst = nest[depth];
        prog[dst] = p + 2;
        prog[p + 1] = dst + 1;
      end
      planted = p + need;
      return ST_OK;
    endfunction

    function logic [2:0] execute(logic [7:0] ib, bit iv, bit ie, output logic [7:0] ob);
      longint unsigned count;
      bit used;
      int unsigned op, p;
      count = 0;
      used = 0;
      ob = 0;
      while (1) begin
        if (count >= limit) return ST_STEP_LIMIT;
        p = ip;
        op = (p < planted) ? prog[p] : OP_HALT;
        if ((op == OP_OPEN || op == OP_CLOSE) && p + 1 >= planted) op = OP_HALT;
        case (op)
          OP_INC: begin tape[cp] = tape[cp] + 1; p++; end
          OP_DEC: begin tape[cp] = tape[cp] - 1; p++; end
          OP_LEFT: begin cp = (cp == 0) ? TAPE_CELLS - 1 : cp - 1; p++; end
          OP_RIGHT: begin cp = (cp + 1 >= TAPE_CELLS) ? 0 : cp + 1; p++; end
          OP_OPEN: p = (tape[cp] == 0) ? prog[p + 1] : p + 2;
          OP_CLOSE: p = (tape[cp] != 0) ? prog[p + 1] : p + 2;
          OP_PUT: begin
            ip = p + 1;
            ob = tape[cp];
            return ST_OUTPUT;
          end
          OP_GET: begin
            if (iv && !used) begin
              tape[cp] = ib;
              used = 1;
            end else if (!ie) begin
              return ST_NEED_INPUT;
            end
            p++;
          end
          default: begin
            mode = MODE_HALTED_M;
            return ST_HALTED;
          end
        endcase
        ip = p;
        count++;
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] ch, logic [7:0] ib, bit iv,
                               bit ie);
      tape_result_t r;
      r.status = ST_OK;
      r.byte_out = 0;
      case (cmd)
        CMD_LOAD: if (mode == MODE_LOADING) r.status = plant(ch);
        CMD_FINISH: begin
          if (mode == MODE_LOADING) begin
            if (fault != ST_OK) begin
              r.status = fault;
              mode = MODE_BROKEN;
            end else if (depth != 0) begin
              r.status = ST_BRACKET;
              mode = MODE_BROKEN;
            end else begin
              prog[planted] = OP_HALT;
              planted++;
              ip = 0;
              mode = MODE_READY;
            end
          end
        end
        CMD_RUN: begin
          if (mode == MODE_READY) r.status = execute(ib, iv, ie, r.byte_out);
          else if (mode == MODE_HALTED_M) r.status = ST_HALTED;
          else r.status = ST_NOT_LOADED;
        end
        default: wipe();
      endcase
      r.length = planted[12:0];
      pending = {pending, r};
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] b, logic [12:0] len);
      tape_result_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d byte %0d length %0d", $time, st, b,
                 len);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (st !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, st);
        errors++;
      end
      if (b !== w.byte_out) begin
        $display("%0t: out_byte expected %0d actual %0d", $time, w.byte_out, b);
        errors++;
      end
      if (len !== w.length) begin
        $display("%0t: program_length expected %0d actual %0d", $time, w.length, len);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_command = CMD_LOAD;
  logic [7:0] in_source_char = 0;
  logic [7:0] in_in_byte = 0;
  logic in_in_valid = 0;
  logic in_in_eof = 0;
  logic out_strobe;
  logic [2:0] out_status;
  logic [7:0] out_out_byte;
  logic [12:0] out_program_length;
  logic cfg_we = 0;
  logic [31:0] cfg_wdata = 0;

  tape_scoreboard sb = new();
  longint cycles = 0;
  bit no_gaps = 0;
  int random_requests = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  bracket_tape_machine_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_source_char(in_source_char), .in_in_byte(in_in_byte),
    .in_in_valid(in_in_valid), .in_in_eof(in_in_eof), .out_strobe(out_strobe),
    .out_status(out_status), .out_out_byte(out_out_byte),
    .out_program_length(out_program_length), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** bracket_tape_machine_unit: FAILED **");
      $finish;
    end
    if (rst_n && out_strobe) sb.check_result(out_status, out_out_byte, out_program_length);
  end

  task automatic send(logic [1:0] cmd, logic [7:0] ch, logic [7:0] ib = 0, bit iv = 0,
                      bit ie = 0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    in_command <= cmd;
    in_source_char <= ch;
    in_in_byte <= ib;
    in_in_valid <= iv;
    in_in_eof <= ie;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, ch, ib, iv, ie);
  endtask

  task automatic load_text(string s);
    foreach (s[i]) send(CMD_LOAD, s[i]);
  endtask

  task automatic settle();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_limit(logic [31:0] v);
    settle();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.limit = v;
    cfg_we <= 0;
  endtask

  task automatic random_run();
    send(CMD_RUN, 8'($urandom), 8'($urandom), $urandom_range(0, 2) != 0,
         1'($urandom_range(0, 1)));
  endtask

  task automatic random_session();
    int n, open, r;
    bit broken;
    string syms;
    syms = "+-<>.,";
    case ($urandom_range(0, 5))
      0: set_limit(1);
      1: set_limit($urandom_range(1, 8));
      default: set_limit($urandom_range(1, 200));
    endcase
    no_gaps = ($urandom_range(0, 3) == 0);
    send(CMD_CLEAR, 8'($urandom));
    n = $urandom_range(3, 40);
    open = 0;
    broken = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 11);
      if (r <= 5) send(CMD_LOAD, syms[r]);
      else if (r == 6 && open < 6) begin send(CMD_LOAD, "["); open++; end
      else if (r == 7 && open > 0) begin send(CMD_LOAD, "]"); open--; end
      else if (r == 8 && broken) send(CMD_LOAD, "]");
      else if (r == 9) send(CMD_LOAD, 8'($urandom));
      else send(CMD_LOAD, ".");
      random_requests++;
    end
    if (!broken)
      while (open > 0) begin send(CMD_LOAD, "]"); open--; random_requests++; end
    send(CMD_FINISH, 8'($urandom));
    n = $urandom_range(20, 60);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom), 1'($urandom),
             1'($urandom));
      else random_run();
      random_requests++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    settle();
    send(CMD_RUN, 0);
    send(CMD_LOAD, 8'h00);
    send(CMD_LOAD, 8'hFF);
    load_text("<-.,.+[-]>.");
    send(CMD_FINISH, 0);
    send(CMD_FINISH, 0);
    send(CMD_LOAD, "+");
    send(CMD_RUN, 0);
    send(CMD_RUN, 0, 8'hA5, 1, 0);
    send(CMD_RUN, 0, 8'h00, 0, 1);
    send(CMD_RUN, 0);
    send(CMD_RUN, 0);

    set_limit(32'hFFFF_FFFF);
    send(CMD_CLEAR, 0);
    load_text("++++[->+<]>.,,.");
    send(CMD_FINISH, 0);
    repeat (4) send(CMD_RUN, 0, 8'h3C, 1, 0);
    send(CMD_RUN, 0, 8'h00, 0, 1);
    send(CMD_RUN, 0);

    set_limit(1);
    send(CMD_CLEAR, 0);
    load_text("]");
    repeat (NEST_DEPTH + 1) send(CMD_LOAD, "[");
    send(CMD_FINISH, 0);
    send(CMD_RUN, 0);

    while (random_requests < 800) random_session();
    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** bracket_tape_machine_unit: PASSED **");
    end else begin
      $display("** bracket_tape_machine_unit: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/bt_pkg.sv
src/bt_ram.sv
src/bracket_tape_machine_unit.sv
dv/bracket_tape_machine_unit_tb.sv
